// File: hw/rtl/lbvs_pkg.sv
// ----------------------------------------------------------------------------
// lbvs_pkg
// Shared types, constants and a fixed-point saturation helper for the vertex skinning block.
// ----------------------------------------------------------------------------
package lbvs_pkg;

    localparam int MAX_BONES_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WEIGHT_BITS   = 16;
    localparam int MAT_ELEMS     = 16;
    localparam int BONE_W        = 6;
    localparam int WT_W          = 17;
    localparam int REQ_W         = 5;
    localparam int IN_W          = 200;
    localparam int OUT_W         = 96;

    localparam logic [REQ_W-1:0] REQ_SKIN     = 5'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_MAX = 5'd16;

    localparam logic [1:0] CFG_SCALE_X = 2'd0;
    localparam logic [1:0] CFG_SCALE_Y = 2'd1;
    localparam logic [1:0] CFG_SCALE_Z = 2'd2;

    typedef struct packed {
        logic signed [31:0]   pos_x;
        logic signed [31:0]   pos_y;
        logic signed [31:0]   pos_z;
        logic [3:0][BONE_W-1:0] bone;
        logic [3:0][WT_W-1:0]   weight;
    } t_vtx;

    function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
        if (v > 80'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -80'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// File: hw/rtl/linear_blend_vertex_skinning.sv
// A skin request passes the table read, accumulate, blend, product, row sum,
// scale and output registers. The one table read port returns one bone matrix a
// cycle unless the output stalls; a new skin request is taken once the previous
// one has read its last matrix. Table loads wait until earlier skin requests
// have finished their table reads. Reset: synchronous, active low; scales go to
// 1.0, the matrix table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning
// Four-bone linear blend vertex skinning in Q16.16 with a loadable bone table.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning #(
    parameter int MAX_BONES = lbvs_pkg::MAX_BONES_DEF,
    parameter int FRAC_BITS = lbvs_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[4:0], pos_x[36:5], pos_y[68:37], pos_z[100:69], bone_0..3[124:101],
    // weight_0..3[192:125], zero fill
    input  logic [lbvs_pkg::IN_W-1:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [lbvs_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    import lbvs_pkg::*;

    localparam int AW = $clog2(MAX_BONES*MAT_ELEMS);

    logic signed [31:0] r_sx, r_sy, r_sz;
    logic          w_wr_en, w_fq_v, w_fq_r, w_qb_v, w_qb_r;
    logic          w_tbl_busy, w_load_hold;
    logic [AW-1:0] w_wr_addr;
    logic [31:0]   w_wr_data;
    t_vtx          w_fq_d, w_qb_d;

    assign w_load_hold = w_qb_v || w_tbl_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= 32'sd65536; r_sy <= 32'sd65536; r_sz <= 32'sd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCALE_X: r_sx <= i_cfg_data;
                CFG_SCALE_Y: r_sy <= i_cfg_data;
                CFG_SCALE_Z: r_sz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lbvs_front #(.MAX_BONES(MAX_BONES)) u_front (
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .i_load_hold(w_load_hold),
        .o_wr_en(w_wr_en), .o_wr_addr(w_wr_addr), .o_wr_data(w_wr_data),
        .o_q_valid(w_fq_v), .i_q_ready(w_fq_r), .o_q_data(w_fq_d)
    );

    lbvs_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_fq_v), .o_ready(w_fq_r), .i_data(w_fq_d),
        .o_valid(w_qb_v), .i_ready(w_qb_r), .o_data(w_qb_d)
    );

    lbvs_back #(.MAX_BONES(MAX_BONES), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_wr_en(w_wr_en), .i_wr_addr(w_wr_addr), .i_wr_data(w_wr_data),
        .i_scale_x(r_sx), .i_scale_y(r_sy), .i_scale_z(r_sz),
        .i_valid(w_qb_v), .o_ready(w_qb_r), .i_data(w_qb_d),
        .o_tbl_busy(w_tbl_busy),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );
endmodule

// File: hw/rtl/lbvs_front.sv
// ----------------------------------------------------------------------------
// lbvs_front
// Request decode: table loads are applied here, skin requests go to the queue.
// ----------------------------------------------------------------------------
module lbvs_front #(
    parameter int MAX_BONES = lbvs_pkg::MAX_BONES_DEF
) (
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [lbvs_pkg::IN_W-1:0] i_data,
    input  logic                    i_load_hold,
    output logic                    o_wr_en,
    output logic [$clog2(MAX_BONES*lbvs_pkg::MAT_ELEMS)-1:0] o_wr_addr,
    output logic [31:0]             o_wr_data,
    output logic                    o_q_valid,
    input  logic                    i_q_ready,
    output lbvs_pkg::t_vtx          o_q_data
);
    import lbvs_pkg::*;

    localparam int AW = $clog2(MAX_BONES*MAT_ELEMS);

    logic [REQ_W-1:0]  w_req;
    logic [BONE_W-1:0] w_bone0;
    logic              w_fire;
    logic [4:0]        w_elem;

    assign w_req   = i_data[4:0];
    assign w_bone0 = i_data[106:101];
    assign w_fire  = i_valid && o_ready;
    assign w_elem  = w_req - 5'd1;

    assign o_q_data.pos_x  = i_data[36:5];
    assign o_q_data.pos_y  = i_data[68:37];
    assign o_q_data.pos_z  = i_data[100:69];
    assign o_q_data.bone   = {i_data[124:119], i_data[118:113], i_data[112:107], w_bone0};
    assign o_q_data.weight = {i_data[192:176], i_data[175:159], i_data[158:142],
                              i_data[141:125]};

    // hold other requests while earlier skin requests still read the table
    assign o_q_valid = i_valid && (w_req == REQ_SKIN);
    assign o_ready   = (w_req == REQ_SKIN) ? i_q_ready : !i_load_hold;

    assign o_wr_en   = w_fire && (w_req != REQ_SKIN) && (w_req <= REQ_LOAD_MAX)
                       && ({3'b0, w_bone0} < 9'(MAX_BONES));
    assign o_wr_addr = AW'(({10'd0, w_bone0} << 4) | {12'd0, w_elem[3:0]});
    assign o_wr_data = i_data[36:5];
endmodule

// File: hw/rtl/lbvs_queue.sv
// ----------------------------------------------------------------------------
// lbvs_queue
// Two-entry queue of pending skin requests between decode and the datapath.
// ----------------------------------------------------------------------------
module lbvs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lbvs_pkg::t_vtx i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output lbvs_pkg::t_vtx o_data
);
    import lbvs_pkg::*;

    t_vtx       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// File: hw/rtl/lbvs_back.sv
// ----------------------------------------------------------------------------
// lbvs_back
// Skinning datapath: reads one bone matrix a cycle unless the output stalls,
// accumulates the weighted blend; a pipelined tail transforms and scales.
// ----------------------------------------------------------------------------
module lbvs_back #(
    parameter int MAX_BONES = lbvs_pkg::MAX_BONES_DEF,
    parameter int FRAC_BITS = lbvs_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_wr_en,
    input  logic [$clog2(MAX_BONES*lbvs_pkg::MAT_ELEMS)-1:0] i_wr_addr,
    input  logic [31:0]             i_wr_data,
    input  logic signed [31:0]      i_scale_x,
    input  logic signed [31:0]      i_scale_y,
    input  logic signed [31:0]      i_scale_z,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  lbvs_pkg::t_vtx          i_data,
    output logic                    o_tbl_busy,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [lbvs_pkg::OUT_W-1:0] o_data
);
    import lbvs_pkg::*;

    localparam int AW = $clog2(MAX_BONES*MAT_ELEMS);
    localparam int SW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam logic signed [79:0] HALF_W = 80'sd1 <<< (WEIGHT_BITS-1);
    localparam logic signed [79:0] HALF_F = 80'sd1 <<< (FRAC_BITS-1);

    // table: one row of 16 words per slot
    logic [MAT_ELEMS*32-1:0] r_mem [MAX_BONES];
    logic [MAT_ELEMS*32-1:0] r_rd;

    // read/accumulate control
    logic        r_busy;
    logic [1:0]  r_idx;
    t_vtx        r_vtx;
    logic        r_rd_v, r_rd_last, r_rd_zero, r_rd_first;
    logic [WT_W-1:0] r_rd_w;
    logic signed [63:0] r_acc [MAT_ELEMS];
    logic        r_acc_done;
    logic signed [31:0] r_px, r_py, r_pz, r_ax, r_ay, r_az;

    // tail stages
    logic        r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_ov;
    logic signed [31:0] r_bl [MAT_ELEMS];
    logic signed [31:0] r_s1_px, r_s1_py, r_s1_pz;
    logic signed [63:0] r_p [9];
    logic signed [31:0] r_b3 [3];
    logic signed [31:0] r_t [3];
    logic signed [63:0] r_q [3];
    logic [OUT_W-1:0]   r_out;

    logic w_adv, w_start, w_slot_ok;
    logic [SW-1:0] w_slot;
    integer k;

    // tail is a plain pipeline stalled as one
    assign w_adv      = !r_ov || i_ready;
    assign o_ready    = w_adv && (!r_busy || r_idx == 2'd3);
    assign w_start    = i_valid && o_ready;
    assign o_tbl_busy = r_busy && (r_idx != 2'd3);
    assign o_valid    = r_ov;
    assign o_data     = r_out;

    logic [5:0] w_cur_bone;
    assign w_cur_bone = w_start ? i_data.bone[0] : r_vtx.bone[r_idx + 2'd1];
    assign w_slot     = SW'(w_cur_bone);
    assign w_slot_ok  = ({3'b0, w_cur_bone} < 9'(MAX_BONES));

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr[AW-1:4]][i_wr_addr[3:0]*32 +: 32] <= i_wr_data;
        end
        if (w_adv && (w_start || (r_busy && r_idx != 2'd3))) begin
            r_rd <= r_mem[w_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_idx <= 2'd0; r_rd_v <= 1'b0; r_acc_done <= 1'b0;
            r_s1_v <= 1'b0; r_s2_v <= 1'b0; r_s3_v <= 1'b0; r_s4_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            if (w_start) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (r_busy) begin
                if (r_idx == 2'd3) r_busy <= 1'b0;
                else r_idx <= r_idx + 2'd1;
            end
            r_rd_v     <= w_start || (r_busy && r_idx != 2'd3);
            r_acc_done <= r_rd_v && r_rd_last;
            r_s1_v <= r_acc_done;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_ov   <= r_s4_v;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_start) begin
                r_vtx <= i_data;
            end
            r_rd_zero <= !w_slot_ok;
            r_rd_w    <= w_start ? i_data.weight[0] : r_vtx.weight[r_idx + 2'd1];
            r_rd_last <= !w_start && r_idx == 2'd2;
            if (w_start) begin
                r_px <= i_data.pos_x; r_py <= i_data.pos_y; r_pz <= i_data.pos_z;
            end
            // accumulate weighted matrix
            if (r_rd_v) begin
                for (k = 0; k < MAT_ELEMS; k = k + 1) begin
                    r_acc[k] <= ((r_rd_first) ? 64'sd0 : r_acc[k])
                        + (r_rd_zero ? 64'sd0 : $signed({1'b0, r_rd_w})
                           * $signed(r_rd[k*32 +: 32]));
                end
                if (r_rd_first) begin
                    r_ax <= r_px; r_ay <= r_py; r_az <= r_pz;
                end
            end
            // blend round and saturate
            for (k = 0; k < MAT_ELEMS; k = k + 1) begin
                r_bl[k] <= sat32((80'(r_acc[k]) + HALF_W) >>> WEIGHT_BITS);
            end
            r_s1_px <= r_ax; r_s1_py <= r_ay; r_s1_pz <= r_az;
            // row products
            for (k = 0; k < 3; k = k + 1) begin
                r_p[k*3+0] <= r_bl[k*4+0] * r_s1_px;
                r_p[k*3+1] <= r_bl[k*4+1] * r_s1_py;
                r_p[k*3+2] <= r_bl[k*4+2] * r_s1_pz;
                r_b3[k]    <= r_bl[k*4+3];
            end
            for (k = 0; k < 3; k = k + 1) begin
                r_t[k] <= sat32(80'(r_b3[k])
                    + ((80'(r_p[k*3+0]) + HALF_F) >>> FRAC_BITS)
                    + ((80'(r_p[k*3+1]) + HALF_F) >>> FRAC_BITS)
                    + ((80'(r_p[k*3+2]) + HALF_F) >>> FRAC_BITS));
            end
            r_q[0] <= i_scale_x * r_t[0];
            r_q[1] <= i_scale_y * r_t[1];
            r_q[2] <= -(i_scale_z * r_t[2]);
            r_out <= {sat32((80'(r_q[2]) + HALF_F) >>> FRAC_BITS),
                      sat32((80'(r_q[1]) + HALF_F) >>> FRAC_BITS),
                      sat32((80'(r_q[0]) + HALF_F) >>> FRAC_BITS)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rd_first <= w_start;
        end
    end
endmodule
